/* hdl/pcmr_pkg.sv */
// Shared types, widths, register indexes and helpers for the PCM requantizer.
`timescale 1ns / 1ps
package pcmr_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CH_W       = 3;
  localparam int SB_W       = 3;
  localparam int GAIN_W     = 24;
  localparam int PCM_W      = 16;
  localparam int W_W        = 41;  // working format: 8 integer, 32 fraction bits
  localparam int PROD_W     = 57;
  localparam int WIDE_W     = 62;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [W_W-1:0]    w_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [PCM_W-1:0]  pcm_t;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 1'd1;

  localparam logic [SB_W-1:0]   SB_RESET   = 3'd2;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1048576;

  localparam w_t   W_ONE     = 41'sh001_0000_0000;
  localparam w_t   W_NEG_ONE = -41'sh001_0000_0000;
  localparam w_t   W_MAX     = 41'sh0FF_FFFF_FFFF;
  localparam w_t   W_MIN     = 41'sh100_0000_0000;
  localparam pcm_t PCM_MAX   = 16'sh7FFF;
  localparam pcm_t PCM_MIN   = 16'sh8000;

  // Clamp a wide signed value into the working format.
  function automatic w_t sat_w(input wide_t x);
    logic all_zero;
    logic all_one;
    all_zero = ~|x[WIDE_W-1:W_W-1];
    all_one  = &x[WIDE_W-1:W_W-1];
    if (all_zero || all_one) begin
      sat_w = x[W_W-1:0];
    end else if (x[WIDE_W-1]) begin
      sat_w = W_MIN;
    end else begin
      sat_w = W_MAX;
    end
  endfunction

endpackage

/* hdl/pcmr_if.sv */
// Channel interfaces: sample input, requantized output and register writes.
`timescale 1ns / 1ps
interface pcmr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcmr_pkg::SAMPLE_W-1:0] sample;
  logic [pcmr_pkg::CH_W-1:0]           channel;
  logic                                end_of_block;

  modport source(output valid, sample, channel, end_of_block, input ready);
  modport sink(input valid, sample, channel, end_of_block, output ready);
endinterface

interface pcmr_out_if;
  logic                  valid;
  logic                  ready;
  pcmr_pkg::pcm_t        pcm_out;
  logic                  end_of_block_out;

  modport source(output valid, pcm_out, end_of_block_out, input ready);
  modport sink(input valid, pcm_out, end_of_block_out, output ready);
endinterface

interface pcmr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcmr_pkg::CFG_IDX_W-1:0]    index;
  logic [pcmr_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/pcm_requantizer_error_feedback.sv */
// Requantizer to 16-bit PCM with gain and per-channel error feedback.
// Takes one sample per clock unless the output stalls and delivers one 16-bit
// result per sample via an input register, a stage holding the scaled value
// (the 32x24 gain multiply and normalizing shift), and the output register fed
// by the error-feedback subtract, saturation and floor. The per-channel error
// is updated as the result enters the output register, so samples of the same
// channel may follow each other in consecutive cycles. Each stage advances
// independently, so a stalled output only holds the stages behind it once they
// are full. Errors clear at reset; no clearing pass. Registers must be written
// only while the block is empty; the block itself does not enforce this.
`timescale 1ns / 1ps
module pcm_requantizer_error_feedback #(
  parameter int CHANNELS = 8
) (
  input logic         clk,
  input logic         rst_n,
  pcmr_in_if.sink     in_if,
  pcmr_out_if.source  out_if,
  pcmr_cfg_if.sink    cfg_if
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [pcmr_pkg::CH_W:0] CH_LIMIT = (pcmr_pkg::CH_W + 1)'(CHANNELS);

  // configuration
  logic [pcmr_pkg::SB_W-1:0]   sample_bytes_r;
  logic [pcmr_pkg::GAIN_W-1:0] gain_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bytes_r <= pcmr_pkg::SB_RESET;
      gain_r         <= pcmr_pkg::GAIN_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        pcmr_pkg::REG_SAMPLE_BYTES: sample_bytes_r <= cfg_if.data[pcmr_pkg::SB_W-1:0];
        pcmr_pkg::REG_GAIN:         gain_r         <= cfg_if.data[pcmr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_v_r, sc_v_r, out_valid_r;
  logic sc_rdy, out_rdy;
  logic in_rdy;

  assign out_rdy = !out_valid_r || out_if.ready;
  assign sc_rdy  = !sc_v_r || out_rdy;
  assign in_rdy  = !in_v_r || sc_rdy;

  assign in_if.ready  = in_rdy;
  assign out_if.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      sc_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_rdy)  in_v_r      <= in_if.valid;
      if (sc_rdy)  sc_v_r      <= in_v_r;
      if (out_rdy) out_valid_r <= sc_v_r;
    end
  end

  // input register
  logic signed [pcmr_pkg::SAMPLE_W-1:0] in_sample_r;
  logic [pcmr_pkg::CH_W-1:0]            in_ch_r;
  logic                                 in_eob_r;

  always_ff @(posedge clk) begin
    if (in_rdy && in_if.valid) begin
      in_sample_r <= in_if.sample;
      in_ch_r     <= in_if.channel;
      in_eob_r    <= in_if.end_of_block;
    end
  end

  // scaling: sample * gain, normalized into the working format
  logic signed [pcmr_pkg::PROD_W-1:0] prod;
  pcmr_pkg::wide_t                     prod_wide;
  pcmr_pkg::wide_t                     scaled_wide;
  pcmr_pkg::w_t                        scaled;

  always_comb begin
    prod      = pcmr_pkg::PROD_W'(in_sample_r) *
                pcmr_pkg::PROD_W'($signed({1'b0, gain_r}));
    prod_wide = pcmr_pkg::wide_t'(prod);
    case (sample_bytes_r) inside
      3'd0, 3'd1: scaled_wide = prod_wide <<< 5;
      3'd2:       scaled_wide = prod_wide >>> 3;
      3'd3:       scaled_wide = prod_wide >>> 11;
      default:    scaled_wide = prod_wide >>> 19;
    endcase
    scaled = pcmr_pkg::sat_w(scaled_wide);
  end

  pcmr_pkg::w_t          sc_val_r;
  logic [CH_IDX_W-1:0]   sc_idx_r;
  logic                  sc_ch_ok_r;
  logic                  sc_eob_r;

  always_ff @(posedge clk) begin
    if (sc_rdy && in_v_r) begin
      sc_val_r   <= scaled;
      sc_idx_r   <= in_ch_r[CH_IDX_W-1:0];
      sc_ch_ok_r <= {1'b0, in_ch_r} < CH_LIMIT;
      sc_eob_r   <= in_eob_r;
    end
  end

  // error feedback and requantization
  pcmr_pkg::w_t            err_r [CHANNELS];
  pcmr_pkg::w_t            err;
  logic signed [pcmr_pkg::W_W:0] diff;
  pcmr_pkg::w_t            fb;
  pcmr_pkg::pcm_t          dst;
  logic signed [pcmr_pkg::W_W:0] nerr_diff;
  pcmr_pkg::w_t            nerr;
  logic                    out_load;

  assign out_load = out_rdy && sc_v_r;

  always_comb begin
    err  = sc_ch_ok_r ? err_r[sc_idx_r] : '0;
    diff = (pcmr_pkg::W_W + 1)'(sc_val_r) - (pcmr_pkg::W_W + 1)'(err);
    fb   = pcmr_pkg::sat_w(pcmr_pkg::wide_t'(diff));
    if (fb >= pcmr_pkg::W_ONE) begin
      dst = pcmr_pkg::PCM_MAX;
    end else if (fb <= pcmr_pkg::W_NEG_ONE) begin
      dst = pcmr_pkg::PCM_MIN;
    end else begin
      dst = fb[pcmr_pkg::PCM_W+16:17];  // floor to a 2^-15 step
    end
    nerr_diff = $signed({{(pcmr_pkg::W_W - pcmr_pkg::PCM_W - 16){dst[pcmr_pkg::PCM_W-1]}},
                         dst, 17'd0}) - (pcmr_pkg::W_W + 1)'(fb);
    nerr      = pcmr_pkg::sat_w(pcmr_pkg::wide_t'(nerr_diff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        err_r[i] <= '0;
      end
    end else if (out_load && sc_ch_ok_r) begin
      err_r[sc_idx_r] <= nerr;
    end
  end

  pcmr_pkg::pcm_t pcm_out_r;
  logic           eob_out_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      pcm_out_r <= dst;
      eob_out_r <= sc_eob_r;
    end
  end

  assign out_if.pcm_out          = pcm_out_r;
  assign out_if.end_of_block_out = eob_out_r;

endmodule
